>>> src/deq_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the double-ended queue with insert.
// No dependencies; used by double_ended_queue_with_insert_top and its testbench.

package deq_pkg;

    // Ring depth; must be a power of two so that ring indices wrap by truncation.
    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    // Count and position width: holds 0..DEPTH.
    localparam int CW    = AW + 1;
    localparam int DW    = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_INSERT     = 3'd4,
        ACT_ERASE      = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

endpackage

>>> src/double_ended_queue_with_insert_top.sv
`timescale 1ns / 1ps
// Double-ended queue with positional insert and erase, held in one ring RAM.
// Insert and erase first shift the N entries between the position and the
// end, where N may be zero; the single RAM read and write port sets the pace,
// one entry moved per cycle. Pushes and inserts then write the new item, and
// every beat reads front and back before the result is offered. The result
// register is valid in the same cycle the next beat can be taken. Reset
// clears head, count and control; RAM contents stay undefined until written.
// Depends on deq_pkg and deq_ram.

module double_ended_queue_with_insert_top (
    input  logic                      clk,
    input  logic                      rst_n,
    // input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                action,
    input  logic [10:0]               position,
    input  logic signed [31:0]        item_value,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic signed [31:0]        front_value,
    output logic signed [31:0]        back_value,
    output logic [10:0]               occupancy,
    output logic                      is_empty
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_WRITE,
        S_RDF,
        S_RDB,
        S_OUT
    } state_t;

    localparam logic [deq_pkg::CW-1:0] DEPTH_C = deq_pkg::CW'(deq_pkg::DEPTH);

    state_t                      state_reg, state_next;
    logic [deq_pkg::AW-1:0]      head_reg, head_next;
    logic [deq_pkg::CW-1:0]      count_reg, count_next;
    deq_pkg::status_t            st_reg, st_next;
    logic [deq_pkg::DW-1:0]      val_reg, val_next;
    logic [deq_pkg::AW-1:0]      woff_reg, woff_next;
    logic                        do_write_reg, do_write_next;
    logic                        ins_reg, ins_next;
    logic [deq_pkg::AW-1:0]      src_reg, src_next;
    logic [deq_pkg::AW-1:0]      dst_reg, dst_next;
    logic [deq_pkg::CW-1:0]      rd_left_reg, rd_left_next;
    logic                        pend_reg, pend_next;
    logic [deq_pkg::DW-1:0]      front_reg, front_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  status_reg, status_next;
    logic [deq_pkg::DW-1:0]      front_value_reg, front_value_next;
    logic [deq_pkg::DW-1:0]      back_value_reg, back_value_next;
    logic [deq_pkg::CW-1:0]      occupancy_reg, occupancy_next;
    logic                        is_empty_reg, is_empty_next;

    // RAM ports
    logic                        ram_we;
    logic [deq_pkg::AW-1:0]      ram_waddr;
    logic [deq_pkg::DW-1:0]      ram_wdata;
    logic                        ram_re;
    logic [deq_pkg::AW-1:0]      ram_raddr;
    logic [deq_pkg::DW-1:0]      ram_rdata;

    logic                        in_accept;
    logic                        out_free;
    logic                        new_empty;

    deq_ram #(
        .AW(deq_pkg::AW),
        .DW(deq_pkg::DW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Take a beat only when the sequencer is idle; the result register may
    // still hold an untaken beat, which S_OUT waits on.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign new_empty = (count_reg == '0);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        st_next          = st_reg;
        val_next         = val_reg;
        woff_next        = woff_reg;
        do_write_next    = do_write_reg;
        ins_next         = ins_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        rd_left_next     = rd_left_reg;
        pend_next        = pend_reg;
        front_next       = front_reg;
        status_next      = status_reg;
        front_value_next = front_value_reg;
        back_value_next  = back_value_reg;
        occupancy_next   = occupancy_reg;
        is_empty_next    = is_empty_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        // drop the result once the far side takes it
        out_valid_next   = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next      = item_value;
                    st_next       = deq_pkg::ST_OK;
                    do_write_next = 1'b0;
                    rd_left_next  = '0;
                    pend_next     = 1'b0;
                    state_next    = S_RDF;
                    case (deq_pkg::action_t'(action))
                        deq_pkg::ACT_PUSH_BACK:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                st_next = deq_pkg::ST_FULL;
                            end
                            else
                            begin
                                woff_next     = count_reg[deq_pkg::AW-1:0];
                                do_write_next = 1'b1;
                                count_next    = count_reg + 1'b1;
                                state_next    = S_WRITE;
                            end
                        end
                        deq_pkg::ACT_PUSH_FRONT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                st_next = deq_pkg::ST_FULL;
                            end
                            else
                            begin
                                head_next     = head_reg - 1'b1;
                                woff_next     = '0;
                                do_write_next = 1'b1;
                                count_next    = count_reg + 1'b1;
                                state_next    = S_WRITE;
                            end
                        end
                        deq_pkg::ACT_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::ACT_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::ACT_INSERT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                st_next = deq_pkg::ST_FULL;
                            end
                            else if (position > count_reg)
                            begin
                                st_next = deq_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                // move entries pos..count-1 one place back, last first
                                woff_next     = position[deq_pkg::AW-1:0];
                                do_write_next = 1'b1;
                                ins_next      = 1'b1;
                                src_next      = count_reg[deq_pkg::AW-1:0] - 1'b1;
                                rd_left_next  = count_reg - position;
                                count_next    = count_reg + 1'b1;
                                state_next    = S_SHIFT;
                            end
                        end
                        deq_pkg::ACT_ERASE:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = deq_pkg::ST_EMPTY;
                            end
                            else if (position >= count_reg)
                            begin
                                st_next = deq_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                // move entries pos+1..count-1 one place forward
                                ins_next     = 1'b0;
                                src_next     = position[deq_pkg::AW-1:0] + 1'b1;
                                rd_left_next = count_reg - position - 1'b1;
                                count_next   = count_reg - 1'b1;
                                state_next   = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            st_next = deq_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // read one source a cycle; write it in the next cycle to its
                // neighbouring slot, so reads and writes never hit the same entry
                if (rd_left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = head_reg + src_reg;
                    src_next     = ins_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    dst_next     = ins_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    rd_left_next = rd_left_reg - 1'b1;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = head_reg + dst_reg;
                    ram_wdata = ram_rdata;
                end
                if ((rd_left_reg == '0) && !pend_reg)
                begin
                    state_next = do_write_reg ? S_WRITE : S_RDF;
                end
            end

            S_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = head_reg + woff_reg;
                ram_wdata  = val_reg;
                state_next = S_RDF;
            end

            S_RDF:
            begin
                ram_re     = 1'b1;
                ram_raddr  = head_reg;
                state_next = S_RDB;
            end

            S_RDB:
            begin
                // hold front, fetch back; back stays in the RAM output register
                front_next = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = head_reg + count_reg[deq_pkg::AW-1:0] - 1'b1;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = st_reg;
                    front_value_next = new_empty ? '1 : front_reg;
                    back_value_next  = new_empty ? '1 : ram_rdata;
                    occupancy_next   = count_reg;
                    is_empty_next    = new_empty;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            pend_reg      <= 1'b0;
            do_write_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            pend_reg      <= pend_next;
            do_write_reg  <= do_write_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        st_reg          <= st_next;
        val_reg         <= val_next;
        woff_reg        <= woff_next;
        ins_reg         <= ins_next;
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        front_reg       <= front_next;
        status_reg      <= status_next;
        front_value_reg <= front_value_next;
        back_value_reg  <= back_value_next;
        occupancy_reg   <= occupancy_next;
        is_empty_reg    <= is_empty_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign front_value = $signed(front_value_reg);
    assign back_value  = $signed(back_value_reg);
    assign occupancy   = occupancy_reg;
    assign is_empty    = is_empty_reg;

    // ---------------------------------------------------------------- checks

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond ring depth");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(count_reg))
        else $error("entry count changed without an accepted beat");

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the result state");

    a_no_write_while_reading_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDF || state_reg == S_RDB || state_reg == S_OUT) |-> !ram_we)
        else $error("RAM write while front and back are fetched");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (is_empty_reg == (occupancy_reg == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule

>>> src/deq_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port, registered read data.
// Generic; no package dependencies.

module deq_ram #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1 << AW) - 1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
